[hw/rtl/nwf_pkg.sv]
// nwf_pkg: types, constants and codes shared by the normalized window filter
// used by nwf_front, nwf_back, the top level and the testbench, no dependencies
`timescale 1ns / 1ps

package nwf_pkg;

  localparam int MAX_LINE_WIDTH = 1024;
  localparam int MAX_KERNEL     = 7;
  localparam int STORE_DEPTH    = MAX_KERNEL * MAX_LINE_WIDTH;
  localparam int WEIGHT_DEPTH   = MAX_KERNEL * MAX_KERNEL;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int WIDX_W         = $clog2(WEIGHT_DEPTH);
  localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
  localparam int IW_W           = 11;
  localparam int IH_W           = 16;
  localparam int K_W            = 3;
  localparam int LIN_W          = IH_W + IW_W;
  localparam int CFG_DATA_W     = 16;
  localparam int SUM_W          = 21;
  localparam int DEN_W          = 14;
  localparam int MAG_W          = 20;
  localparam int DVS_W          = 13;

  typedef enum logic [1:0] {
    ACT_WEIGHT = 2'd0,
    ACT_PIXEL  = 2'd1,
    ACT_DRAIN  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_KERNEL_WIDTH  = 2'd2,
    CFG_KERNEL_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SETUP,
    BK_TAP,
    BK_FLUSH,
    BK_PREP,
    BK_DIV,
    BK_DONE
  } back_state_e;

  // effective (clamped) geometry
  typedef struct packed {
    logic [IW_W-1:0] width;
    logic [IH_W-1:0] height;
    logic [K_W-1:0]  kw;
    logic [K_W-1:0]  kh;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [IH_W-1:0]   row;
    logic [ADDR_W-1:0] addr;
    logic              plane_end;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_chan_t;

  typedef struct packed {
    logic idle;
    logic job_pop;
  } back_status_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       plane_end;
  } result_t;

endpackage

[hw/rtl/nwf_ram.sv]
// nwf_ram: generic single write port, single registered read port memory
// no dependencies
`timescale 1ns / 1ps

module nwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/nwf_front.sv]
// nwf_front: input stage, raster position tracking, weight and pixel writes
// and the job queue toward the back end; depends on nwf_pkg
`timescale 1ns / 1ps

module nwf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nwf_pkg::cfg_t               cfg_i,
  input  logic                        restart_i,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [1:0]                  action_i,
  input  logic [7:0]                  sample_value_i,
  input  nwf_pkg::back_status_t       back_i,
  output nwf_pkg::job_chan_t          job_o,
  output logic                        st_we_o,
  output logic [nwf_pkg::ADDR_W-1:0]  st_waddr_o,
  output logic [7:0]                  st_wdata_o,
  output logic                        wt_we_o,
  output logic [nwf_pkg::WIDX_W-1:0]  wt_waddr_o,
  output logic [7:0]                  wt_wdata_o
);
  import nwf_pkg::*;

  logic              item_valid_q, item_valid_d;
  logic [1:0]        item_act_q;
  logic [7:0]        item_val_q;
  logic [COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [IH_W-1:0]   in_row_q, in_row_d, out_row_q, out_row_d;
  logic [LIN_W-1:0]  in_lin_q, in_lin_d;
  logic [ADDR_W-1:0] in_addr_q, in_addr_d, out_addr_q, out_addr_d;
  logic              pending_q, pending_d;
  logic [WIDX_W-1:0] widx_q, widx_d;
  job_t              jq_q [2];
  logic              jq_rd_q, jq_rd_d, jq_wr_q, jq_wr_d;
  logic [1:0]        jq_cnt_q, jq_cnt_d;

  logic [K_W-1:0]    reach_r, reach_c;
  logic [13:0]       lag_rows;
  logic [LIN_W-1:0]  lag;
  logic              idle_all, go, do_it, accept, fire, push_job, pop_job;
  logic              in_col_last, in_row_last, in_wrap;
  logic [COL_W-1:0]  p_col;
  logic [IH_W-1:0]   p_row;
  logic [ADDR_W-1:0] p_addr;
  logic              p_col_last, p_row_last, out_wrap;
  logic [WIDX_W-1:0] widx_last;
  job_t              job_new;

  assign reach_r   = cfg_i.kh - K_W'(1) - (cfg_i.kh >> 1);
  assign reach_c   = cfg_i.kw - K_W'(1) - (cfg_i.kw >> 1);
  assign lag_rows  = 14'(reach_r) * 14'(cfg_i.width);
  assign lag       = LIN_W'(lag_rows) + LIN_W'(reach_c);
  assign widx_last = WIDX_W'(WIDX_W'(cfg_i.kw) * WIDX_W'(cfg_i.kh) - WIDX_W'(1));
  assign idle_all  = back_i.idle && (jq_cnt_q == 2'd0);
  assign fire      = (in_lin_q >= lag);

  assign in_col_last = (IW_W'(in_col_q) == cfg_i.width - IW_W'(1));
  assign in_row_last = (in_row_q == cfg_i.height - IH_W'(1));
  assign in_wrap     = in_col_last && in_row_last;

  // a pixel after a finished plane restarts the output position
  always_comb begin
    if ((item_act_q == ACT_PIXEL) && pending_q) begin
      p_col  = '0;
      p_row  = '0;
      p_addr = '0;
    end else begin
      p_col  = out_col_q;
      p_row  = out_row_q;
      p_addr = out_addr_q;
    end
  end

  assign p_col_last = (IW_W'(p_col) == cfg_i.width - IW_W'(1));
  assign p_row_last = (p_row == cfg_i.height - IH_W'(1));
  assign out_wrap   = p_col_last && p_row_last;

  always_comb begin
    job_new.col       = p_col;
    job_new.row       = p_row;
    job_new.addr      = p_addr;
    job_new.plane_end = out_wrap;
  end

  always_comb begin
    unique case (item_act_q)
      ACT_WEIGHT: go = idle_all;
      ACT_PIXEL:  go = (jq_cnt_q != 2'd2) && (!(pending_q || (in_lin_q == '0)) || idle_all);
      ACT_DRAIN:  go = (jq_cnt_q != 2'd2);
      default:    go = 1'b1;
    endcase
  end

  assign do_it   = item_valid_q && go;
  assign full_o  = item_valid_q && !go;
  assign accept  = push_i && !full_o;
  assign pop_job = back_i.job_pop && (jq_cnt_q != 2'd0);

  always_comb begin
    item_valid_d = accept ? 1'b1 : (do_it ? 1'b0 : item_valid_q);
    in_col_d     = in_col_q;
    in_row_d     = in_row_q;
    in_lin_d     = in_lin_q;
    in_addr_d    = in_addr_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    out_addr_d   = out_addr_q;
    pending_d    = pending_q;
    widx_d       = widx_q;
    st_we_o      = 1'b0;
    wt_we_o      = 1'b0;
    push_job     = 1'b0;
    if (restart_i) begin
      in_col_d   = '0;
      in_row_d   = '0;
      in_lin_d   = '0;
      in_addr_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_addr_d = '0;
      pending_d  = 1'b0;
      widx_d     = '0;
    end else if (do_it) begin
      unique case (item_act_q)
        ACT_WEIGHT: begin
          wt_we_o = 1'b1;
          widx_d  = (widx_q == widx_last) ? '0 : widx_q + WIDX_W'(1);
        end
        ACT_PIXEL: begin
          st_we_o    = 1'b1;
          out_col_d  = p_col;
          out_row_d  = p_row;
          out_addr_d = p_addr;
          pending_d  = 1'b0;
          if (fire) begin
            push_job   = 1'b1;
            out_col_d  = p_col_last ? '0 : p_col + COL_W'(1);
            out_row_d  = p_col_last ? (p_row_last ? '0 : p_row + IH_W'(1)) : p_row;
            out_addr_d = out_wrap ? '0 :
                         ((p_addr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : p_addr + ADDR_W'(1));
          end
          if (in_wrap && !(fire && out_wrap)) begin
            pending_d = 1'b1;
          end
          in_col_d  = in_col_last ? '0 : in_col_q + COL_W'(1);
          in_row_d  = in_col_last ? (in_row_last ? '0 : in_row_q + IH_W'(1)) : in_row_q;
          in_lin_d  = in_wrap ? '0 : in_lin_q + LIN_W'(1);
          in_addr_d = in_wrap ? '0 :
                      ((in_addr_q == ADDR_W'(STORE_DEPTH - 1)) ? '0 : in_addr_q + ADDR_W'(1));
        end
        ACT_DRAIN: begin
          if (pending_q) begin
            push_job   = 1'b1;
            out_col_d  = p_col_last ? '0 : p_col + COL_W'(1);
            out_row_d  = p_col_last ? (p_row_last ? '0 : p_row + IH_W'(1)) : p_row;
            out_addr_d = out_wrap ? '0 :
                         ((p_addr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : p_addr + ADDR_W'(1));
            if (out_wrap) begin
              pending_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    jq_wr_d  = push_job ? ~jq_wr_q : jq_wr_q;
    jq_rd_d  = pop_job ? ~jq_rd_q : jq_rd_q;
    jq_cnt_d = jq_cnt_q + 2'(push_job) - 2'(pop_job);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      in_col_q     <= '0;
      in_row_q     <= '0;
      in_lin_q     <= '0;
      in_addr_q    <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      out_addr_q   <= '0;
      pending_q    <= 1'b0;
      widx_q       <= '0;
      jq_rd_q      <= 1'b0;
      jq_wr_q      <= 1'b0;
      jq_cnt_q     <= '0;
    end else begin
      item_valid_q <= item_valid_d;
      in_col_q     <= in_col_d;
      in_row_q     <= in_row_d;
      in_lin_q     <= in_lin_d;
      in_addr_q    <= in_addr_d;
      out_col_q    <= out_col_d;
      out_row_q    <= out_row_d;
      out_addr_q   <= out_addr_d;
      pending_q    <= pending_d;
      widx_q       <= widx_d;
      jq_rd_q      <= jq_rd_d;
      jq_wr_q      <= jq_wr_d;
      jq_cnt_q     <= jq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_act_q <= action_i;
      item_val_q <= sample_value_i;
    end
    if (push_job) begin
      jq_q[jq_wr_q] <= job_new;
    end
  end

  assign job_o.valid = (jq_cnt_q != 2'd0);
  assign job_o.job   = jq_q[jq_rd_q];
  assign st_waddr_o  = in_addr_q;
  assign st_wdata_o  = item_val_q;
  assign wt_waddr_o  = widx_q;
  assign wt_wdata_o  = item_val_q;

endmodule

[hw/rtl/nwf_back.sv]
// nwf_back: per-pixel tap walk with one multiply-accumulate, radix-2 divider
// and the result queue; depends on nwf_pkg
`timescale 1ns / 1ps

module nwf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nwf_pkg::cfg_t               cfg_i,
  input  nwf_pkg::job_chan_t          job_i,
  output nwf_pkg::back_status_t       status_o,
  output logic [nwf_pkg::ADDR_W-1:0]  st_raddr_o,
  input  logic [7:0]                  st_rdata_i,
  output logic [nwf_pkg::WIDX_W-1:0]  wt_raddr_o,
  input  logic [7:0]                  wt_rdata_i,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [7:0]                  filtered_pixel_o,
  output logic                        plane_end_o
);
  import nwf_pkg::*;

  back_state_e              state_q, state_d;
  job_t                     job_q, job_d;
  logic [K_W-1:0]           i_q, i_d, j_q, j_d;
  logic [WIDX_W-1:0]        k_q, k_d;
  logic signed [17:0]       ty_q, ty_d;
  logic signed [11:0]       tx_q, tx_d, tx0_q, tx0_d;
  logic [ADDR_W-1:0]        row_addr_q, row_addr_d, tap_addr_q, tap_addr_d;
  logic                     tap_ok_q, tap_ok_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [DEN_W-1:0]  den_q, den_d;
  logic                     neg_q, neg_d, zero_q, zero_d;
  logic [MAG_W-1:0]         mag_q, mag_d;
  logic [DVS_W-1:0]         dvs_q, dvs_d;
  logic [DVS_W-1:0]         rem_q, rem_d;
  logic [4:0]               cnt_q, cnt_d;
  result_t                  of_q [2];
  logic                     of_rd_q, of_wr_q;
  logic [1:0]               of_cnt_q;

  logic signed [7:0]        pix_s, wt_s;
  logic signed [15:0]       prod;
  logic [12:0]              off;
  logic signed [ADDR_W:0]   start_addr;
  logic [ADDR_W:0]          next_row;
  logic                     inb, last_j, last_i, of_push, of_pop;
  logic [DVS_W:0]           trial;
  logic                     trial_ge;
  logic signed [SUM_W:0]    sum_neg;
  logic signed [DEN_W:0]    den_neg;
  logic signed [MAG_W+1:0]  qs, vs;
  result_t                  res;

  assign pix_s = $signed(st_rdata_i ^ 8'h80);
  assign wt_s  = $signed(wt_rdata_i ^ 8'h80);
  assign prod  = pix_s * wt_s;

  assign off        = 13'(cfg_i.kh >> 1) * 13'(cfg_i.width) + 13'(cfg_i.kw >> 1);
  assign start_addr = $signed({1'b0, job_q.addr}) - $signed({1'b0, off});
  assign next_row   = {1'b0, row_addr_q} + (ADDR_W + 1)'(cfg_i.width);

  assign inb = (ty_q >= 0) && (ty_q < $signed({2'b00, cfg_i.height})) &&
               (tx_q >= 0) && (tx_q < $signed({1'b0, cfg_i.width}));
  assign last_j = (j_q == cfg_i.kw - K_W'(1));
  assign last_i = (i_q == cfg_i.kh - K_W'(1));

  assign trial    = {rem_q, mag_q[MAG_W-1]};
  assign trial_ge = (trial >= {1'b0, dvs_q});
  assign sum_neg  = -(SUM_W + 1)'(sum_q);
  assign den_neg  = -(DEN_W + 1)'(den_q);

  assign qs = neg_q ? -$signed({2'b00, mag_q}) : $signed({2'b00, mag_q});
  assign vs = qs + (MAG_W + 2)'(128);

  always_comb begin
    res.plane_end = job_q.plane_end;
    if (zero_q || vs < 0) begin
      res.pixel = 8'd0;
    end else if (vs > (MAG_W + 2)'(255)) begin
      res.pixel = 8'd255;
    end else begin
      res.pixel = vs[7:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    ty_d       = ty_q;
    tx_d       = tx_q;
    tx0_d      = tx0_q;
    row_addr_d = row_addr_q;
    tap_addr_d = tap_addr_q;
    tap_ok_d   = 1'b0;
    sum_d      = sum_q;
    den_d      = den_q;
    neg_d      = neg_q;
    zero_d     = zero_q;
    mag_d      = mag_q;
    dvs_d      = dvs_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    of_push    = 1'b0;
    status_o.idle    = (state_q == BK_IDLE);
    status_o.job_pop = 1'b0;
    if (tap_ok_q) begin
      sum_d = sum_q + SUM_W'(prod);
      den_d = den_q + DEN_W'(wt_s);
    end
    unique case (state_q)
      BK_IDLE: begin
        if (job_i.valid) begin
          status_o.job_pop = 1'b1;
          job_d   = job_i.job;
          state_d = BK_SETUP;
        end
      end
      BK_SETUP: begin
        ty_d       = $signed({2'b00, job_q.row}) - $signed(18'(cfg_i.kh >> 1));
        tx_d       = $signed({2'b00, job_q.col}) - $signed(12'(cfg_i.kw >> 1));
        tx0_d      = $signed({2'b00, job_q.col}) - $signed(12'(cfg_i.kw >> 1));
        row_addr_d = (start_addr < 0) ? ADDR_W'(start_addr + (ADDR_W + 1)'(STORE_DEPTH)) :
                                        ADDR_W'(start_addr);
        tap_addr_d = (start_addr < 0) ? ADDR_W'(start_addr + (ADDR_W + 1)'(STORE_DEPTH)) :
                                        ADDR_W'(start_addr);
        i_d        = '0;
        j_d        = '0;
        k_d        = '0;
        sum_d      = '0;
        den_d      = '0;
        state_d    = BK_TAP;
      end
      BK_TAP: begin
        tap_ok_d = inb;
        k_d      = k_q + WIDX_W'(1);
        if (last_j) begin
          j_d  = '0;
          i_d  = i_q + K_W'(1);
          ty_d = ty_q + 18'sd1;
          tx_d = tx0_q;
          if (next_row >= (ADDR_W + 1)'(STORE_DEPTH)) begin
            row_addr_d = ADDR_W'(next_row - (ADDR_W + 1)'(STORE_DEPTH));
            tap_addr_d = ADDR_W'(next_row - (ADDR_W + 1)'(STORE_DEPTH));
          end else begin
            row_addr_d = ADDR_W'(next_row);
            tap_addr_d = ADDR_W'(next_row);
          end
          if (last_i) begin
            state_d = BK_FLUSH;
          end
        end else begin
          j_d        = j_q + K_W'(1);
          tx_d       = tx_q + 12'sd1;
          tap_addr_d = (tap_addr_q == ADDR_W'(STORE_DEPTH - 1)) ? '0 :
                       tap_addr_q + ADDR_W'(1);
        end
      end
      BK_FLUSH: begin
        state_d = BK_PREP;
      end
      BK_PREP: begin
        zero_d  = (sum_q == 0) || (den_q == 0);
        neg_d   = sum_q[SUM_W-1] ^ den_q[DEN_W-1];
        mag_d   = sum_q[SUM_W-1] ? MAG_W'(sum_neg) : MAG_W'(sum_q);
        dvs_d   = den_q[DEN_W-1] ? DVS_W'(den_neg) : DVS_W'(den_q);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ((sum_q == 0) || (den_q == 0)) ? BK_DONE : BK_DIV;
      end
      BK_DIV: begin
        rem_d = trial_ge ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
        mag_d = {mag_q[MAG_W-2:0], trial_ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(MAG_W - 1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (of_cnt_q != 2'd2) begin
          of_push = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign of_pop = pop_i && (of_cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      tap_ok_q <= 1'b0;
      of_rd_q  <= 1'b0;
      of_wr_q  <= 1'b0;
      of_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      tap_ok_q <= tap_ok_d;
      of_rd_q  <= of_pop ? ~of_rd_q : of_rd_q;
      of_wr_q  <= of_push ? ~of_wr_q : of_wr_q;
      of_cnt_q <= of_cnt_q + 2'(of_push) - 2'(of_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    i_q        <= i_d;
    j_q        <= j_d;
    k_q        <= k_d;
    ty_q       <= ty_d;
    tx_q       <= tx_d;
    tx0_q      <= tx0_d;
    row_addr_q <= row_addr_d;
    tap_addr_q <= tap_addr_d;
    sum_q      <= sum_d;
    den_q      <= den_d;
    neg_q      <= neg_d;
    zero_q     <= zero_d;
    mag_q      <= mag_d;
    dvs_q      <= dvs_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    if (of_push) begin
      of_q[of_wr_q] <= res;
    end
  end

  assign st_raddr_o       = tap_addr_q;
  assign wt_raddr_o       = k_q;
  assign empty_o          = (of_cnt_q == 2'd0);
  assign filtered_pixel_o = of_q[of_rd_q].pixel;
  assign plane_end_o      = of_q[of_rd_q].plane_end;

endmodule

[hw/rtl/normalized_window_filter.sv]
// normalized_window_filter: top level, configuration registers, line store and
// weight memories; depends on nwf_pkg, nwf_ram, nwf_front, nwf_back
`timescale 1ns / 1ps

// Streaming normalized 2-D window filter. Weights (action 0) and pixels
// (action 1) enter through a queue-style port; results leave in raster order
// with plane_end on the last pixel of a plane, and drain beats (action 2) flush
// outputs still owed after a plane. For each output the back end walks the
// kernel_width * kernel_height taps one after another through the single read
// port of the line store and one multiply-accumulate, then runs a radix-2
// divider for a 20-bit quotient, and takes no new job until the result is
// queued. A weight beat, and the first pixel of each plane, wait until all
// earlier outputs are computed. The line store needs no clearing after reset.
// A configuration write restarts the stream.
module normalized_window_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [nwf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      action_i,
  input  logic [7:0]                      sample_value_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      filtered_pixel_o,
  output logic                            plane_end_o
);
  import nwf_pkg::*;

  logic [IW_W-1:0]   iw_q;
  logic [IH_W-1:0]   ih_q;
  logic [K_W-1:0]    kw_q, kh_q;
  cfg_t              cfg;
  back_status_t      back_status;
  job_chan_t         job_chan;
  logic              st_we, wt_we;
  logic [ADDR_W-1:0] st_waddr, st_raddr;
  logic [WIDX_W-1:0] wt_waddr, wt_raddr;
  logic [7:0]        st_wdata, st_rdata, wt_wdata, wt_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_q <= IW_W'(640);
      ih_q <= IH_W'(480);
      kw_q <= K_W'(3);
      kh_q <= K_W'(3);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:   iw_q <= cfg_data_i[IW_W-1:0];
        CFG_IMAGE_HEIGHT:  ih_q <= cfg_data_i[IH_W-1:0];
        CFG_KERNEL_WIDTH:  kw_q <= cfg_data_i[K_W-1:0];
        CFG_KERNEL_HEIGHT: kh_q <= cfg_data_i[K_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (iw_q == '0) begin
      cfg.width = IW_W'(1);
    end else if (iw_q > IW_W'(MAX_LINE_WIDTH)) begin
      cfg.width = IW_W'(MAX_LINE_WIDTH);
    end else begin
      cfg.width = iw_q;
    end
    cfg.height = (ih_q == '0) ? IH_W'(1) : ih_q;
    cfg.kw     = (kw_q == '0) ? K_W'(1) : kw_q;
    cfg.kh     = (kh_q == '0) ? K_W'(1) : kh_q;
  end

  nwf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .restart_i      (cfg_we_i),
    .push_i         (push),
    .full_o         (full),
    .action_i       (action_i),
    .sample_value_i (sample_value_i),
    .back_i         (back_status),
    .job_o          (job_chan),
    .st_we_o        (st_we),
    .st_waddr_o     (st_waddr),
    .st_wdata_o     (st_wdata),
    .wt_we_o        (wt_we),
    .wt_waddr_o     (wt_waddr),
    .wt_wdata_o     (wt_wdata)
  );

  nwf_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_line_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  nwf_ram #(.WIDTH(8), .DEPTH(WEIGHT_DEPTH)) u_weights (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i (wt_waddr),
    .wdata_i (wt_wdata),
    .raddr_i (wt_raddr),
    .rdata_o (wt_rdata)
  );

  nwf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .job_i            (job_chan),
    .status_o         (back_status),
    .st_raddr_o       (st_raddr),
    .st_rdata_i       (st_rdata),
    .wt_raddr_o       (wt_raddr),
    .wt_rdata_i       (wt_rdata),
    .pop_i            (pop),
    .empty_o          (empty),
    .filtered_pixel_o (filtered_pixel_o),
    .plane_end_o      (plane_end_o)
  );

endmodule

[hw/rtl/nwf_checker.sv]
// nwf_checker: port-level checks of the normalized window filter, bound to the top
// no dependencies
`timescale 1ns / 1ps

module nwf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            full,
  input logic                            empty,
  input logic                            pop,
  input logic [7:0]                      filtered_pixel_o,
  input logic                            plane_end_o
);

  // waiting result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(filtered_pixel_o) && $stable(plane_end_o))
    else $error("result beat changed while waiting");

  // queues come out of reset empty
  assert property (@(posedge clk_i) !rst_ni |=> empty && !full)
    else $error("queues not empty in reset");

  // results leave only by pop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("result lost without pop");

endmodule

bind normalized_window_filter nwf_checker u_nwf_checker (.*);

[verif/normalized_window_filter_test.sv]
// normalized_window_filter_test: self-checking testbench for the normalized window filter
// drives weights, pixels and drains through the queue ports and checks against a built-in model
// depends on nwf_pkg and normalized_window_filter
`timescale 1ns / 1ps

module normalized_window_filter_test;
  import nwf_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 200;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [1:0]            cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [1:0]            action_i = '0;
  logic [7:0]            sample_value_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [7:0]            filtered_pixel_o;
  logic                  plane_end_o;

  normalized_window_filter dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .push, .full,
    .action_i, .sample_value_i, .empty, .pop, .filtered_pixel_o, .plane_end_o
  );

  always #2 clk_i = ~clk_i;

  // model state
  logic [IW_W-1:0] m_width  = 11'd640;
  logic [IH_W-1:0] m_height = 16'd480;
  logic [K_W-1:0]  m_kw     = 3'd3;
  logic [K_W-1:0]  m_kh     = 3'd3;
  byte unsigned    pix_mem[STORE_DEPTH];
  byte unsigned    wt_mem[WEIGHT_DEPTH];
  int              in_col, in_row, out_col, out_row, wt_idx;
  bit              owed;

  result_t         pending_pixels[$];
  int              errors = 0;
  int              burst_left = 0;
  int              hold_cycles = 0;
  int              idle_count = 0;

  function automatic int eff_w();
    return (m_width == 0) ? 1 : (m_width > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : int'(m_width);
  endfunction
  function automatic int eff_h();
    return (m_height == 0) ? 1 : int'(m_height);
  endfunction
  function automatic int eff_kw();
    return (m_kw == 0) ? 1 : int'(m_kw);
  endfunction
  function automatic int eff_kh();
    return (m_kh == 0) ? 1 : int'(m_kh);
  endfunction

  function automatic bit raster_next(inout int c, inout int r);
    c++;
    if (c >= eff_w()) begin
      c = 0;
      r++;
      if (r >= eff_h()) begin
        r = 0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void queue_window_result();
    int sum, den, ty, tx, p, k, v;
    result_t res;
    sum = 0;
    den = 0;
    for (int i = 0; i < eff_kh(); i++) begin
      ty = out_row - eff_kh() / 2 + i;
      for (int j = 0; j < eff_kw(); j++) begin
        tx = out_col - eff_kw() / 2 + j;
        if (ty >= 0 && ty < eff_h() && tx >= 0 && tx < eff_w()) begin
          p = int'(pix_mem[(ty * eff_w() + tx) % STORE_DEPTH]) - 128;
          k = int'(wt_mem[(i * eff_kw() + j) % WEIGHT_DEPTH]) - 128;
          sum += p * k;
          den += k;
        end
      end
    end
    if (sum == 0 || den == 0) v = 0;
    else begin
      v = sum / den + 128;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
    end
    res.pixel = v[7:0];
    res.plane_end = (out_col == eff_w() - 1 && out_row == eff_h() - 1);
    pending_pixels.push_back(res);
  endfunction

  function automatic void filter_predict(logic [1:0] act, logic [7:0] val);
    int lin, lag;
    bit in_wrap, out_wrap;
    out_wrap = 1'b0;
    case (act)
      ACT_WEIGHT: begin
        wt_mem[wt_idx % WEIGHT_DEPTH] = val;
        wt_idx++;
        if (wt_idx >= eff_kw() * eff_kh()) wt_idx = 0;
      end
      ACT_PIXEL: begin
        if (owed) begin
          out_col = 0;
          out_row = 0;
          owed = 1'b0;
        end
        lin = in_row * eff_w() + in_col;
        pix_mem[lin % STORE_DEPTH] = val;
        lag = (eff_kh() - 1 - eff_kh() / 2) * eff_w() + (eff_kw() - 1 - eff_kw() / 2);
        in_wrap = raster_next(in_col, in_row);
        if (lin >= lag) begin
          queue_window_result();
          out_wrap = raster_next(out_col, out_row);
        end
        if (in_wrap && !out_wrap) owed = 1'b1;
      end
      ACT_DRAIN: begin
        if (owed) begin
          queue_window_result();
          if (raster_next(out_col, out_row)) owed = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(logic [1:0] act, logic [7:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push <= 1'b1;
    action_i <= act;
    sample_value_i <= val;
    do @(posedge clk_i); while (full);
    filter_predict(act, val);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  m_width = val[IW_W-1:0];
      CFG_IMAGE_HEIGHT: m_height = val;
      CFG_KERNEL_WIDTH: m_kw = val[K_W-1:0];
      default:          m_kh = val[K_W-1:0];
    endcase
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; wt_idx = 0; owed = 1'b0;
  endtask

  task automatic set_geometry(int w, int h, int kw, int kh);
    write_reg(CFG_IMAGE_WIDTH, w[15:0]);
    write_reg(CFG_IMAGE_HEIGHT, h[15:0]);
    write_reg(CFG_KERNEL_WIDTH, kw[15:0]);
    write_reg(CFG_KERNEL_HEIGHT, kh[15:0]);
  endtask

  task automatic load_kernel();
    repeat (eff_kw() * eff_kh()) send_beat(ACT_WEIGHT, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain_plane();
    while (owed) send_beat(ACT_DRAIN, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_reset_geometry();
    load_kernel();
    repeat (660) send_beat(ACT_PIXEL, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed();
    set_geometry(4, 3, 3, 3);
    send_beat(ACT_WEIGHT, 8'd0);
    send_beat(ACT_WEIGHT, 8'd255);
    send_beat(ACT_WEIGHT, 8'd128);
    send_beat(ACT_WEIGHT, 8'd255);
    send_beat(ACT_WEIGHT, 8'd0);
    send_beat(ACT_WEIGHT, 8'd255);
    send_beat(ACT_WEIGHT, 8'd129);
    send_beat(ACT_WEIGHT, 8'd127);
    send_beat(ACT_WEIGHT, 8'd255);
    send_beat(ACT_DRAIN, 8'hff);
    send_beat(2'd3, 8'hff);
    for (int n = 0; n < 12; n++) send_beat(ACT_PIXEL, n[0] ? 8'd255 : 8'd0);
    send_beat(2'd3, 8'h00);
    drain_plane();
    send_beat(ACT_DRAIN, 8'h00);
  endtask

  task automatic test_geometry_extremes();
    set_geometry(2047, 0, 7, 1);
    load_kernel();
    repeat (40) send_beat(ACT_PIXEL, 8'($urandom_range(0, 255)));
    set_geometry(1024, 1, 1, 7);
    load_kernel();
    repeat (8) send_beat(ACT_PIXEL, 8'($urandom_range(0, 255)));
    set_geometry(3, 65535, 0, 0);
    send_beat(ACT_WEIGHT, 8'd200);
    repeat (20) send_beat(ACT_PIXEL, 8'($urandom_range(0, 255)));
    set_geometry(5, 0, 7, 7);
    load_kernel();
    repeat (5) send_beat(ACT_PIXEL, 8'($urandom_range(0, 255)));
    drain_plane();
    set_geometry(0, 2, 6, 2);
    load_kernel();
    repeat (2) send_beat(ACT_PIXEL, 8'd255);
    drain_plane();
  endtask

  task automatic test_random_planes();
    int kind, n;
    repeat (10) begin
      set_geometry($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(0, 7),
                   $urandom_range(0, 7));
      load_kernel();
      repeat ($urandom_range(2, 4)) begin
        kind = $urandom_range(0, 9);
        n = (kind == 8) ? $urandom_range(1, eff_w() * eff_h()) : eff_w() * eff_h();
        if (kind == 9) begin
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 2))
              0: send_beat(2'd3, 8'($urandom_range(0, 255)));
              1: send_beat(ACT_DRAIN, 8'($urandom_range(0, 255)));
              default: send_beat(ACT_WEIGHT, 8'($urandom_range(0, 255)));
            endcase
          end
        end else begin
          repeat (n) begin
            if ($urandom_range(0, 39) == 0) send_beat(ACT_WEIGHT, 8'($urandom_range(0, 255)));
            send_beat(ACT_PIXEL, 8'($urandom_range(0, 255)));
          end
          if (kind < 7) drain_plane();
          else if (kind == 7 && owed) send_beat(ACT_DRAIN, 8'($urandom_range(0, 255)));
        end
      end
      drain_plane();
    end
  endtask

  task automatic test_backpressure();
    set_geometry(6, 4, 3, 3);
    load_kernel();
    hold_cycles = 3000;
    repeat (72) send_beat(ACT_PIXEL, 8'($urandom_range(0, 255)));
    drain_plane();
  endtask

  // receiver: steps through four stall patterns in turn
  int pop_phase = 0;
  always @(posedge clk_i) begin
    pop_phase <= pop_phase + 1;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      case ((pop_phase >> 7) % 4)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 1) == 0);
        2: pop <= ($urandom_range(0, 5) == 0);
        default: pop <= (pop_phase % 3 != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: actual pixel %0d plane_end %0b", $time,
                 filtered_pixel_o, plane_end_o);
      end else begin
        want = pending_pixels.pop_front();
        if (want.pixel !== filtered_pixel_o) begin
          errors++;
          $display("%0t pixel mismatch: expected %0d actual %0d", $time, want.pixel,
                   filtered_pixel_o);
        end
        if (want.plane_end !== plane_end_o) begin
          errors++;
          $display("%0t plane_end mismatch: expected %0b actual %0b", $time,
                   want.plane_end, plane_end_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; wt_idx = 0; owed = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_directed();
    test_geometry_extremes();
    test_random_planes();
    test_backpressure();
    wait_idle();
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/nwf_pkg.sv
hw/rtl/nwf_ram.sv
hw/rtl/nwf_front.sv
hw/rtl/nwf_back.sv
hw/rtl/normalized_window_filter.sv
hw/rtl/nwf_checker.sv
verif/normalized_window_filter_test.sv
